/* design/assert_macros.svh */
// assertion helpers shared by the cache modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/sawb_pkg.sv */
// ----------------------------------------------------------------------------
// sawb_pkg
// shared constants, codes and control types for the lru cache
// ----------------------------------------------------------------------------
package sawb_pkg;

    localparam int MEM_WORDS_DEF       = 256;
    localparam int MAX_BLOCK_WORDS_DEF = 8;
    localparam int MAX_SETS_DEF        = 8;
    localparam int MAX_WAYS_DEF        = 4;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_PRELOAD = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] ACT_C2P  = 3'd0;
    localparam logic [2:0] ACT_P2C  = 3'd1;
    localparam logic [2:0] ACT_M2C  = 3'd2;
    localparam logic [2:0] ACT_C2M  = 3'd3;
    localparam logic [2:0] ACT_DISC = 3'd4;
    localparam logic [2:0] ACT_PRE  = 3'd5;

    localparam logic [1:0] CFG_BLOCK = 2'd0;
    localparam logic [1:0] CFG_SETS  = 2'd1;
    localparam logic [1:0] CFG_WAYS  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_WB_RD,
        ST_WB_WR,
        ST_WB_OUT,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_FILL_OUT,
        ST_WORD_RD,
        ST_WORD_OUT,
        ST_PRE_OUT,
        ST_CLEAR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_lines;
        logic mem_clear;
        logic pre_write;
        logic pick_victim;
        logic wb_mem_rd;
        logic wb_mem_wr;
        logic fill_mem_rd;
        logic fill_line_wr;
        logic fill_done;
        logic word_rd;
        logic word_wr;
        logic touch;
        logic cnt_clr;
        logic cnt_inc;
        logic out_load;
        logic [2:0] out_action;
        logic out_last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic hit;
        logic victim_valid;
        logic victim_dirty;
        logic cnt_last;
        logic clr_last;
        logic out_busy;
    } status_t;

endpackage

/* design/sawb_ram.sv */
// ----------------------------------------------------------------------------
// sawb_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module sawb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* design/sawb_ctrl.sv */
// ----------------------------------------------------------------------------
// sawb_ctrl
// sequencer for memory clear, lookup, write-back, fill, word and preload transfers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sawb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  sawb_pkg::status_t  st,
    output sawb_pkg::cmd_t     cmd
);

    sawb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sawb_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sawb_pkg::ST_CLEAR:
            begin
                if (st.clr_last)
                begin
                    state_next = sawb_pkg::ST_IDLE;
                end
            end
            sawb_pkg::ST_IDLE:
            begin
                if (in_valid && !cfg_valid)
                begin
                    state_next = sawb_pkg::ST_LOOKUP;
                end
            end
            sawb_pkg::ST_LOOKUP:
            begin
                case (st.op)
                    sawb_pkg::OP_PRELOAD: state_next = sawb_pkg::ST_PRE_OUT;
                    sawb_pkg::OP_NONE:    state_next = sawb_pkg::ST_IDLE;
                    default:              state_next = sawb_pkg::ST_DECIDE;
                endcase
            end
            sawb_pkg::ST_DECIDE:
            begin
                if (st.hit)
                begin
                    state_next = sawb_pkg::ST_WORD_RD;
                end
                else if (st.victim_valid && st.victim_dirty)
                begin
                    state_next = sawb_pkg::ST_WB_RD;
                end
                else if (st.victim_valid)
                begin
                    state_next = sawb_pkg::ST_WB_OUT;
                end
                else
                begin
                    state_next = sawb_pkg::ST_FILL_RD;
                end
            end
            sawb_pkg::ST_WB_RD:   state_next = sawb_pkg::ST_WB_WR;
            sawb_pkg::ST_WB_WR:
            begin
                state_next = st.cnt_last ? sawb_pkg::ST_WB_OUT : sawb_pkg::ST_WB_RD;
            end
            sawb_pkg::ST_WB_OUT:
            begin
                if (!st.out_busy)
                begin
                    state_next = sawb_pkg::ST_FILL_RD;
                end
            end
            sawb_pkg::ST_FILL_RD: state_next = sawb_pkg::ST_FILL_WR;
            sawb_pkg::ST_FILL_WR:
            begin
                state_next = st.cnt_last ? sawb_pkg::ST_FILL_OUT : sawb_pkg::ST_FILL_RD;
            end
            sawb_pkg::ST_FILL_OUT:
            begin
                if (!st.out_busy)
                begin
                    state_next = sawb_pkg::ST_WORD_RD;
                end
            end
            sawb_pkg::ST_WORD_RD: state_next = sawb_pkg::ST_WORD_OUT;
            sawb_pkg::ST_WORD_OUT,
            sawb_pkg::ST_PRE_OUT:
            begin
                if (!st.out_busy)
                begin
                    state_next = sawb_pkg::ST_IDLE;
                end
            end
            default: state_next = sawb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            sawb_pkg::ST_CLEAR:   cmd.mem_clear = 1'b1;
            sawb_pkg::ST_IDLE:
            begin
                cfg_ready = !st.out_busy;
                in_ready = !cfg_valid;
                cmd.capture = in_valid && !cfg_valid;
                cmd.clear_lines = cfg_valid && !st.out_busy;
            end
            sawb_pkg::ST_LOOKUP:
            begin
                cmd.pick_victim = 1'b1;
                cmd.cnt_clr = 1'b1;
                cmd.pre_write = (st.op == sawb_pkg::OP_PRELOAD);
            end
            sawb_pkg::ST_DECIDE: ;
            sawb_pkg::ST_WB_RD:   cmd.wb_mem_rd = 1'b1;
            sawb_pkg::ST_WB_WR:
            begin
                cmd.wb_mem_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            sawb_pkg::ST_WB_OUT:
            begin
                cmd.out_load = !st.out_busy;
                cmd.out_action = st.victim_dirty ? sawb_pkg::ACT_C2M : sawb_pkg::ACT_DISC;
                cmd.cnt_clr = 1'b1;
            end
            sawb_pkg::ST_FILL_RD: cmd.fill_mem_rd = 1'b1;
            sawb_pkg::ST_FILL_WR:
            begin
                cmd.fill_line_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            sawb_pkg::ST_FILL_OUT:
            begin
                cmd.out_load = !st.out_busy;
                cmd.out_action = sawb_pkg::ACT_M2C;
                cmd.fill_done = !st.out_busy;
            end
            sawb_pkg::ST_WORD_RD:
            begin
                cmd.word_rd = 1'b1;
            end
            sawb_pkg::ST_WORD_OUT:
            begin
                cmd.word_rd = 1'b1;
                cmd.out_load = !st.out_busy;
                cmd.out_action = (st.op == sawb_pkg::OP_READ) ? sawb_pkg::ACT_C2P
                                                              : sawb_pkg::ACT_P2C;
                cmd.out_last = 1'b1;
                cmd.word_wr = !st.out_busy && (st.op == sawb_pkg::OP_WRITE);
                cmd.touch = !st.out_busy;
            end
            sawb_pkg::ST_PRE_OUT:
            begin
                cmd.out_load = !st.out_busy;
                cmd.out_action = sawb_pkg::ACT_PRE;
                cmd.out_last = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    `ASSERT_IMPL(a_cfg_only_idle, clk, rst_n, cfg_ready, state_reg == sawb_pkg::ST_IDLE)
    `ASSERT_NEXT(a_capture_lookup, clk, rst_n, cmd.capture, state_reg == sawb_pkg::ST_LOOKUP)
    `ASSERT_IMPL(a_no_load_busy, clk, rst_n, cmd.out_load, !st.out_busy)

endmodule

/* design/sawb_dp.sv */
// ----------------------------------------------------------------------------
// sawb_dp
// tag store, lru ages, line and backing memories, output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sawb_dp #(
    parameter int MEM_WORDS       = sawb_pkg::MEM_WORDS_DEF,
    parameter int MAX_BLOCK_WORDS = sawb_pkg::MAX_BLOCK_WORDS_DEF,
    parameter int MAX_SETS        = sawb_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS        = sawb_pkg::MAX_WAYS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sawb_pkg::cmd_t     cmd,
    output sawb_pkg::status_t  st,
    input  logic [1:0]         opcode,
    input  logic [7:0]         address,
    input  logic signed [31:0] write_data,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         action,
    output logic [7:0]         start_address,
    output logic [3:0]         length,
    output logic signed [31:0] read_data,
    output logic               last
);

    localparam int NLINES = MAX_SETS * MAX_WAYS;
    localparam int SW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int OW  = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
    localparam int LW  = (NLINES > 1) ? $clog2(NLINES) : 1;
    localparam int DD  = NLINES * MAX_BLOCK_WORDS;
    localparam int DW  = (DD > 1) ? $clog2(DD) : 1;
    localparam int MW  = $clog2(MEM_WORDS);
    localparam int CW  = OW + 1;
    localparam int AW  = $clog2(MAX_WAYS + 1);

    logic [1:0] b_reg, s_reg;
    logic [2:0] w_reg;
    logic [1:0] op_reg;
    logic [7:0] addr_reg;
    logic [31:0] wd_reg;
    logic [7:0] tag_st  [NLINES];
    logic [NLINES-1:0] valid_reg, dirty_reg;
    logic [WW-1:0] age_reg [NLINES];
    logic [WW-1:0] way_reg;
    logic hit_reg, vvalid_reg, vdirty_reg;
    logic [7:0] vhead_reg;
    logic [CW-1:0] cnt_reg;
    logic [MW-1:0] clr_reg;
    logic out_valid_reg;

    // effective geometry
    logic [1:0] b_eff, s_eff;
    logic [AW-1:0] nw;
    logic [3:0] bw;
    logic [7:0] tag, head;
    logic [SW-1:0] set;
    logic [OW-1:0] off;

    always_comb
    begin
        b_eff = b_reg;
        while_b: for (int i = 0; i < 3; i++)
        begin
            if (b_eff > 2'd0 && (32'd1 << b_eff) > MAX_BLOCK_WORDS)
            begin
                b_eff = b_eff - 2'd1;
            end
        end
        s_eff = s_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (s_eff > 2'd0 && (32'd1 << s_eff) > MAX_SETS)
            begin
                s_eff = s_eff - 2'd1;
            end
        end
        if (w_reg == 3'd0)
        begin
            nw = AW'(1);
        end
        else if (32'(w_reg) > MAX_WAYS)
        begin
            nw = AW'(MAX_WAYS);
        end
        else
        begin
            nw = AW'(w_reg);
        end
    end

    assign bw   = 4'd1 << b_eff;
    assign off  = OW'(addr_reg & 8'((bw - 4'd1)));
    assign set  = SW'((addr_reg >> b_eff) & 8'((4'd1 << s_eff) - 4'd1));
    assign tag  = addr_reg >> (3'(b_eff) + 3'(s_eff));
    assign head = addr_reg & ~8'(bw - 4'd1);

    // lookup over the ways of the set
    logic hit_c, inv_c;
    logic [WW-1:0] hway_c, iway_c, oway_c;
    always_comb
    begin
        hit_c = 1'b0;
        inv_c = 1'b0;
        hway_c = '0;
        iway_c = '0;
        oway_c = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (w < nw)
            begin
                if (valid_reg[LW'(set) * MAX_WAYS + w]
                    && tag_st[LW'(set) * MAX_WAYS + w] == tag)
                begin
                    hit_c = 1'b1;
                    hway_c = WW'(w);
                end
                if (!valid_reg[LW'(set) * MAX_WAYS + w])
                begin
                    inv_c = 1'b1;
                    iway_c = WW'(w);
                end
            end
        end
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (w < nw && age_reg[LW'(set) * MAX_WAYS + w]
                > age_reg[LW'(set) * MAX_WAYS + 32'(oway_c)])
            begin
                oway_c = WW'(w);
            end
        end
    end

    logic [LW-1:0] line;
    assign line = LW'(LW'(set) * MAX_WAYS) + LW'(way_reg);

    // memories
    logic mem_we;
    logic [MW-1:0] mem_a;
    logic [31:0] mem_wd, mem_rd;
    logic dat_we;
    logic [DW-1:0] dat_a;
    logic [31:0] dat_wd, dat_rd;
    logic [OW-1:0] cnt_o;

    assign cnt_o = cnt_reg[OW-1:0];

    always_comb
    begin
        mem_we = cmd.mem_clear || cmd.pre_write || cmd.wb_mem_wr;
        if (cmd.mem_clear)
        begin
            mem_wd = '0;
        end
        else
        begin
            mem_wd = cmd.pre_write ? wd_reg : dat_rd;
        end
        if (cmd.mem_clear)
        begin
            mem_a = clr_reg;
        end
        else if (cmd.pre_write)
        begin
            mem_a = MW'(addr_reg);
        end
        else if (cmd.wb_mem_wr)
        begin
            mem_a = MW'(vhead_reg + 8'(cnt_o));
        end
        else if (cmd.fill_mem_rd)
        begin
            mem_a = MW'(head + 8'(cnt_o));
        end
        else
        begin
            mem_a = MW'(addr_reg);
        end
        dat_we = cmd.fill_line_wr || cmd.word_wr;
        dat_wd = cmd.word_wr ? wd_reg : mem_rd;
        if (cmd.word_rd || cmd.word_wr)
        begin
            dat_a = DW'(DW'(line) * MAX_BLOCK_WORDS) + DW'(off);
        end
        else if (cmd.wb_mem_rd || cmd.fill_line_wr)
        begin
            dat_a = DW'(DW'(line) * MAX_BLOCK_WORDS) + DW'(cnt_o);
        end
        else
        begin
            dat_a = DW'(DW'(line) * MAX_BLOCK_WORDS) + DW'(off);
        end
    end

    sawb_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_a), .wdata(mem_wd), .rdata(mem_rd)
    );

    sawb_ram #(.WIDTH(32), .DEPTH(DD)) u_dat (
        .clk(clk), .we(dat_we), .addr(dat_a), .wdata(dat_wd), .rdata(dat_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
            wd_reg   <= write_data;
        end
        if (cmd.pick_victim)
        begin
            hit_reg <= hit_c;
            way_reg <= hit_c ? hway_c : (inv_c ? iway_c : oway_c);
            vvalid_reg <= !hit_c && !inv_c;
            vdirty_reg <= dirty_reg[LW'(set) * MAX_WAYS + 32'(inv_c ? iway_c : oway_c)];
            vhead_reg <= (tag_st[LW'(set) * MAX_WAYS + 32'(oway_c)]
                          << (3'(b_eff) + 3'(s_eff))) | (8'(set) << b_eff);
        end
        if (cmd.fill_done)
        begin
            tag_st[line] <= tag;
        end
    end

    logic [CW-1:0] bw_c;
    assign bw_c = CW'(bw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= 2'd0;
            s_reg <= 2'd0;
            w_reg <= 3'd1;
            valid_reg <= '0;
            dirty_reg <= '0;
            cnt_reg <= '0;
            clr_reg <= '0;
            for (int i = 0; i < NLINES; i++)
            begin
                age_reg[i] <= WW'(i % MAX_WAYS);
            end
        end
        else
        begin
            if (cmd.mem_clear)
            begin
                clr_reg <= clr_reg + MW'(1);
            end
            if (cmd.clear_lines)
            begin
                case (cfg_index)
                    sawb_pkg::CFG_BLOCK: b_reg <= cfg_data[1:0];
                    sawb_pkg::CFG_SETS:  s_reg <= cfg_data[1:0];
                    sawb_pkg::CFG_WAYS:  w_reg <= cfg_data;
                    default: ;
                endcase
                if (cfg_index != sawb_pkg::OP_NONE)
                begin
                    valid_reg <= '0;
                    dirty_reg <= '0;
                    for (int i = 0; i < NLINES; i++)
                    begin
                        age_reg[i] <= WW'(i % MAX_WAYS);
                    end
                end
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.fill_done)
            begin
                valid_reg[line] <= 1'b1;
                dirty_reg[line] <= 1'b0;
            end
            if (cmd.word_wr)
            begin
                dirty_reg[line] <= 1'b1;
            end
            if (cmd.touch)
            begin
                for (int w = 0; w < MAX_WAYS; w++)
                begin
                    if (w < nw && WW'(w) != way_reg
                        && age_reg[LW'(set) * MAX_WAYS + w] < age_reg[line]
                        && 32'(age_reg[LW'(set) * MAX_WAYS + w]) < MAX_WAYS - 1)
                    begin
                        age_reg[LW'(set) * MAX_WAYS + w] <=
                            age_reg[LW'(set) * MAX_WAYS + w] + WW'(1);
                    end
                end
                age_reg[line] <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            action <= cmd.out_action;
            last   <= cmd.out_last;
            read_data <= '0;
            unique case (cmd.out_action)
                sawb_pkg::ACT_C2M, sawb_pkg::ACT_DISC:
                begin
                    start_address <= vhead_reg;
                    length <= bw;
                end
                sawb_pkg::ACT_M2C:
                begin
                    start_address <= head;
                    length <= bw;
                end
                sawb_pkg::ACT_C2P:
                begin
                    start_address <= addr_reg;
                    length <= 4'd1;
                    read_data <= dat_rd;
                end
                default:
                begin
                    start_address <= addr_reg;
                    length <= 4'd1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        st.op = op_reg;
        st.hit = hit_reg;
        st.victim_valid = vvalid_reg;
        st.victim_dirty = vdirty_reg;
        st.cnt_last = (cnt_reg + CW'(1)) == bw_c;
        st.clr_last = clr_reg == MW'(MEM_WORDS - 1);
        st.out_busy = out_valid_reg && !out_ready;
    end

    `ASSERT_NEXT(a_fill_sets_valid, clk, rst_n, cmd.fill_done, valid_reg[$past(line)])
    `ASSERT_IMPL(a_cnt_in_block, clk, rst_n, cmd.cnt_inc, cnt_reg < bw_c)
    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg)

endmodule

/* design/set_assoc_write_back_lru_cache.sv */
// ----------------------------------------------------------------------------
// set_assoc_write_back_lru_cache
// write-back write-allocate lru cache in front of a word memory
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       input      in_valid in_ready opcode address write_data
// out      output     out_valid out_ready action start_address length read_data last
// cfg      input      cfg_valid cfg_ready cfg_index cfg_data
//
// a dirty victim is written back word by word before its record, a clean
// one only gets a record; the fill reads the block word by word before
// its record, all through the single port line and backing memories
// after reset the backing memory is zeroed one word at a time with input
// and config held off; valid, dirty and ages reset at once
// a stalled output holds the sequencer at its next record
// ----------------------------------------------------------------------------
module set_assoc_write_back_lru_cache #(
    parameter int MEM_WORDS       = sawb_pkg::MEM_WORDS_DEF,
    parameter int MAX_BLOCK_WORDS = sawb_pkg::MAX_BLOCK_WORDS_DEF,
    parameter int MAX_SETS        = sawb_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS        = sawb_pkg::MAX_WAYS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [7:0]         address,
    input  logic signed [31:0] write_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         action,
    output logic [7:0]         start_address,
    output logic [3:0]         length,
    output logic signed [31:0] read_data,
    output logic               last
);

    sawb_pkg::cmd_t    cmd;
    sawb_pkg::status_t st;

    sawb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .st(st), .cmd(cmd)
    );

    sawb_dp #(
        .MEM_WORDS(MEM_WORDS), .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS),
        .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .opcode(opcode), .address(address), .write_data(write_data),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready), .action(action),
        .start_address(start_address), .length(length),
        .read_data(read_data), .last(last)
    );

endmodule

/* tb/tb_set_assoc_write_back_lru_cache.sv */
// ----------------------------------------------------------------------------
// tb_set_assoc_write_back_lru_cache
// Self-checking bench for the write-back lru cache. Every accepted request
// runs through a behavioral copy of the cache and its backing memory, and
// the transfer records it yields are queued. Each record the block emits
// is compared field by field with the oldest queued record. A directed
// table comes first, then random traffic under several geometries, with
// random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_set_assoc_write_back_lru_cache;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLINES  = sawb_pkg::MAX_SETS_DEF * sawb_pkg::MAX_WAYS_DEF;
    localparam int NWAYS   = sawb_pkg::MAX_WAYS_DEF;
    localparam int BWORDS  = sawb_pkg::MAX_BLOCK_WORDS_DEF;
    localparam int NWORDS  = sawb_pkg::MEM_WORDS_DEF;
    localparam int WD_LIMIT = 3000;

    typedef struct {
        logic [2:0]  act;
        logic [7:0]  start;
        logic [3:0]  len;
        logic [31:0] rdata;
        logic        lst;
    } xfer_t;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  addr;
        logic [31:0] wdata;
        bit          typed;
        logic [2:0]  t_act;
        logic [31:0] t_rdata;
    } row_t;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [1:0]         opcode = '0;
    logic [7:0]         address = '0;
    logic signed [31:0] write_data = '0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [2:0]         cfg_data = '0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [2:0]         action;
    logic [7:0]         start_address;
    logic [3:0]         length;
    logic signed [31:0] read_data;
    logic               last;

    set_assoc_write_back_lru_cache dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] mem_q [NWORDS];
    logic [31:0] ldata_q [NLINES * BWORDS];
    logic [7:0]  ltag_q [NLINES];
    bit          lvalid_q [NLINES];
    bit          ldirty_q [NLINES];
    int          lage_q [NLINES];
    int          blk_log2 = 0, set_log2 = 0, way_cfg = 1;

    xfer_t pending_xfers [$];
    int    errors = 0;
    int    send_idle_pct = 0, recv_idle_pct = 0;
    int    hold_off = 0;
    int    quiet_cycles = 0;

    task automatic clear_lines();
        for (int i = 0; i < NLINES; i++)
        begin
            lvalid_q[i] = 0;
            ldirty_q[i] = 0;
            lage_q[i]   = i % NWAYS;
        end
    endtask

    task automatic push_xfer(logic [2:0] a, logic [7:0] s, logic [3:0] l,
                             logic [31:0] d, logic lst);
        xfer_t x;
        x.act = a; x.start = s; x.len = l; x.rdata = d; x.lst = lst;
        pending_xfers.push_back(x);
    endtask

    task automatic cache_predict(logic [1:0] op, logic [7:0] addr, logic [31:0] wd);
        int nw, bw, off, set, base, way, line, a, vhead, head;
        logic [7:0] tag;
        bit hit, found;
        if (op == sawb_pkg::OP_PRELOAD)
        begin
            mem_q[addr] = wd;
            push_xfer(sawb_pkg::ACT_PRE, addr, 1, 0, 1);
            return;
        end
        if (op == sawb_pkg::OP_NONE)
            return;
        nw   = (way_cfg < 1) ? 1 : (way_cfg > NWAYS) ? NWAYS : way_cfg;
        bw   = 1 << blk_log2;
        off  = addr & (bw - 1);
        set  = (addr >> blk_log2) & ((1 << set_log2) - 1);
        tag  = addr >> (blk_log2 + set_log2);
        head = addr & ~(bw - 1) & 8'hff;
        base = set * NWAYS;
        hit  = 0;
        way  = 0;
        for (int w = 0; w < nw; w++)
            if (!hit && lvalid_q[base + w] && ltag_q[base + w] == tag)
            begin
                hit = 1;
                way = w;
            end
        if (!hit)
        begin
            found = 0;
            for (int w = 0; w < nw; w++)
                if (!found && !lvalid_q[base + w])
                begin
                    found = 1;
                    way = w;
                end
            if (!found)
            begin
                way = 0;
                for (int w = 1; w < nw; w++)
                    if (lage_q[base + w] > lage_q[base + way])
                        way = w;
            end
            line = base + way;
            if (lvalid_q[line])
            begin
                vhead = ((ltag_q[line] << (blk_log2 + set_log2)) | (set << blk_log2)) & 8'hff;
                if (ldirty_q[line])
                begin
                    for (int k = 0; k < bw; k++)
                        mem_q[(vhead + k) % NWORDS] = ldata_q[line * BWORDS + k];
                    push_xfer(sawb_pkg::ACT_C2M, vhead, bw, 0, 0);
                end
                else
                    push_xfer(sawb_pkg::ACT_DISC, vhead, bw, 0, 0);
            end
            for (int k = 0; k < bw; k++)
                ldata_q[line * BWORDS + k] = mem_q[(head + k) % NWORDS];
            ltag_q[line]   = tag;
            lvalid_q[line] = 1;
            ldirty_q[line] = 0;
            push_xfer(sawb_pkg::ACT_M2C, head, bw, 0, 0);
        end
        line = base + way;
        if (op == sawb_pkg::OP_READ)
            push_xfer(sawb_pkg::ACT_C2P, addr, 1, ldata_q[line * BWORDS + off], 1);
        else
        begin
            ldata_q[line * BWORDS + off] = wd;
            ldirty_q[line] = 1;
            push_xfer(sawb_pkg::ACT_P2C, addr, 1, 0, 1);
        end
        a = lage_q[line];
        for (int w = 0; w < nw; w++)
            if (w != way && lage_q[base + w] < a && lage_q[base + w] < NWAYS - 1)
                lage_q[base + w]++;
        lage_q[line] = 0;
    endtask

    // request channel; valid stays up between back-to-back transfers
    task automatic send_req(row_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid   <= 1;
        opcode     <= r.op;
        address    <= r.addr;
        write_data <= r.wdata;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cache_predict(r.op, r.addr, r.wdata);
        if (r.typed && pending_xfers.size() > 0)
        begin
            pending_xfers[$].act   = r.t_act;
            pending_xfers[$].rdata = r.t_rdata;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        @(posedge clk);
        while (pending_xfers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [2:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        if (idx == sawb_pkg::CFG_BLOCK)
            blk_log2 = val[1:0];
        else if (idx == sawb_pkg::CFG_SETS)
            set_log2 = val[1:0];
        else if (idx == sawb_pkg::CFG_WAYS)
            way_cfg = val;
        clear_lines();
        @(posedge clk);
    endtask

    // output side: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        xfer_t x;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_xfers.size() == 0)
            begin
                $error("unexpected transfer action=%0d start=%0d", action, start_address);
                errors++;
            end
            else
            begin
                x = pending_xfers.pop_front();
                if (action !== x.act)
                begin
                    $error("action exp %0d got %0d", x.act, action);
                    errors++;
                end
                if (start_address !== x.start)
                begin
                    $error("start_address exp %0d got %0d", x.start, start_address);
                    errors++;
                end
                if (length !== x.len)
                begin
                    $error("length exp %0d got %0d", x.len, length);
                    errors++;
                end
                if (read_data !== x.rdata)
                begin
                    $error("read_data exp %h got %h", x.rdata, read_data);
                    errors++;
                end
                if (last !== x.lst)
                begin
                    $error("last exp %0d got %0d", x.lst, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    row_t dir_rows [] = '{
        '{sawb_pkg::OP_PRELOAD, 8'd0,   32'h80000000, 1, sawb_pkg::ACT_PRE, 32'h0},
        '{sawb_pkg::OP_PRELOAD, 8'd255, 32'h7fffffff, 1, sawb_pkg::ACT_PRE, 32'h0},
        '{sawb_pkg::OP_PRELOAD, 8'd1,   32'h00000000, 1, sawb_pkg::ACT_PRE, 32'h0},
        '{sawb_pkg::OP_READ,    8'd0,   32'h0,        1, sawb_pkg::ACT_C2P, 32'h80000000},
        '{sawb_pkg::OP_READ,    8'd0,   32'h0,        1, sawb_pkg::ACT_C2P, 32'h80000000},
        '{sawb_pkg::OP_WRITE,   8'd0,   32'hffffffff, 1, sawb_pkg::ACT_P2C, 32'h0},
        '{sawb_pkg::OP_READ,    8'd0,   32'h0,        1, sawb_pkg::ACT_C2P, 32'hffffffff},
        '{sawb_pkg::OP_READ,    8'd255, 32'h0,        1, sawb_pkg::ACT_C2P, 32'h7fffffff},
        '{sawb_pkg::OP_READ,    8'd0,   32'h0,        1, sawb_pkg::ACT_C2P, 32'hffffffff},
        '{sawb_pkg::OP_PRELOAD, 8'd0,   32'h12345678, 1, sawb_pkg::ACT_PRE, 32'h0},
        '{sawb_pkg::OP_READ,    8'd0,   32'h0,        1, sawb_pkg::ACT_C2P, 32'hffffffff},
        '{sawb_pkg::OP_NONE,    8'd0,   32'h0,        0, sawb_pkg::ACT_C2P, 32'h0},
        '{sawb_pkg::OP_WRITE,   8'd255, 32'h7fffffff, 0, sawb_pkg::ACT_C2P, 32'h0},
        '{sawb_pkg::OP_WRITE,   8'd1,   32'h00000000, 1, sawb_pkg::ACT_P2C, 32'h0},
        '{sawb_pkg::OP_READ,    8'd1,   32'h0,        1, sawb_pkg::ACT_C2P, 32'h0},
        '{sawb_pkg::OP_READ,    8'd128, 32'h0,        0, sawb_pkg::ACT_C2P, 32'h0},
        '{sawb_pkg::OP_WRITE,   8'd127, 32'h55aa55aa, 0, sawb_pkg::ACT_C2P, 32'h0},
        '{sawb_pkg::OP_NONE,    8'd255, 32'hffffffff, 0, sawb_pkg::ACT_C2P, 32'h0}
    };

    int cfg_set [6][3] = '{'{3, 3, 7}, '{1, 2, 0}, '{2, 1, 3}, '{3, 0, 4},
                           '{0, 3, 2}, '{0, 0, 1}};

    initial
    begin
        row_t r;
        int   win;
        int   pick;
        for (int i = 0; i < NWORDS; i++)
            mem_q[i] = 0;
        clear_lines();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 68;
        foreach (dir_rows[i])
            send_req(dir_rows[i]);
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_cfg(sawb_pkg::CFG_BLOCK, 3'(cfg_set[p][0]));
            write_cfg(sawb_pkg::CFG_SETS, 3'(cfg_set[p][1]));
            write_cfg(sawb_pkg::CFG_WAYS, 3'(cfg_set[p][2]));
            case (p % 3)
                0: begin send_idle_pct = 12; recv_idle_pct = 68; end
                1: begin send_idle_pct = 68; recv_idle_pct = 12; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (p == 2)
                hold_off = 300;
            win = $urandom_range(255);
            for (int n = 0; n < 38; n++)
            begin
                pick = $urandom_range(99);
                r.op    = (pick < 45) ? sawb_pkg::OP_READ : (pick < 85) ? sawb_pkg::OP_WRITE :
                          (pick < 95) ? sawb_pkg::OP_PRELOAD : sawb_pkg::OP_NONE;
                r.addr  = ($urandom_range(1)) ? 8'(win + $urandom_range(31)) : 8'($urandom);
                r.wdata = $urandom;
                r.typed = 0;
                send_req(r);
                if (r.op == sawb_pkg::OP_NONE)
                    n--;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
